[hdl/interrupt_storm_latency_monitor_defines.svh]
// Assertion macros shared by the interrupt storm and latency monitor RTL.
`ifndef INTERRUPT_STORM_LATENCY_MONITOR_DEFINES_SVH
`define INTERRUPT_STORM_LATENCY_MONITOR_DEFINES_SVH

// ante implies cons in the same cycle
`define ISM_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

`define ISM_ASSERT_LATER2(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> ##2 (cons)) \
		else $error(msg);

// expr never holds
`define ISM_ASSERT_NEVER(label, ck, rn, expr, msg) \
	label: assert property (@(posedge ck) disable iff (!(rn)) !(expr)) \
		else $error(msg);

`endif

[hdl/ism_pkg.sv]
// Types and constants for the interrupt storm and latency monitor.
package ism_pkg;

	localparam int LINE_W = 10;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MONITOR_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT_MS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LATENCY_LIMIT_MS = 2'd3;

	localparam logic CMD_ENTRY = 1'b0;
	localparam logic CMD_EXIT  = 1'b1;

	localparam logic [DATA_W-1:0] COUNT_LIMIT_RST   = 32'd30000;
	localparam logic [DATA_W-1:0] WINDOW_LIMIT_RST  = 32'd1000;
	localparam logic [DATA_W-1:0] LATENCY_LIMIT_RST = 32'd1000;
	localparam logic [DATA_W-1:0] COUNT_MAX         = 32'hFFFF_FFFF;

	typedef struct packed {
		logic              cmd;
		logic [LINE_W-1:0] line_number;
		logic              per_cpu_line;
		logic [DATA_W-1:0] now_ms;
	} ism_item_t;

	typedef struct packed {
		logic              ignored;
		logic              storm_detected;
		logic              long_latency;
		logic [DATA_W-1:0] elapsed_ms;
		logic [DATA_W-1:0] line_count;
	} ism_result_t;

	// one line table entry: window start over event count
	typedef struct packed {
		logic [DATA_W-1:0] window_start;
		logic [DATA_W-1:0] event_count;
	} ism_entry_t;

endpackage

[hdl/ism_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ism_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/interrupt_storm_latency_monitor.sv]
// Interrupt storm and latency monitor top level.
//
//  channel   handshake              payload
//  -------   ---------------------  ----------------------------
//  item      start, busy            item   (ism_item_t)
//  result    done (one-cycle pulse) result (ism_result_t)
//  config    cfg_wen                cfg_index, cfg_data
//
// A beat accepted at one edge gives its result on done through valid_s1 and
// the result register: the accept edge reads the line table RAM, the next cycle
// updates the entry and registers the result. Outside the clearing pass one beat
// per cycle is taken; a beat on the line just written uses the forwarded entry.
// After reset a clearing pass zeroes the line table, busy high.
// The receiver cannot stall; results are never held.
`include "interrupt_storm_latency_monitor_defines.svh"

module interrupt_storm_latency_monitor
	import ism_pkg::*;
#(
	parameter int LINES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ism_item_t            item,
	output logic                 done,
	output ism_result_t          result,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(LINES);
	localparam int LW1 = LINE_W + 1;
	localparam logic [LW1-1:0] LINE_END = LW1'(LINES);
	localparam logic [AW-1:0] LAST_IDX = AW'(LINES - 1);
	localparam int EW = $bits(ism_entry_t);

	// configuration
	logic              enable_q;
	logic [DATA_W-1:0] count_limit_q;
	logic [DATA_W-1:0] window_limit_q;
	logic [DATA_W-1:0] latency_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			count_limit_q   <= COUNT_LIMIT_RST;
			window_limit_q  <= WINDOW_LIMIT_RST;
			latency_limit_q <= LATENCY_LIMIT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MONITOR_ENABLE:   enable_q        <= cfg_data[0];
				REG_COUNT_LIMIT:      count_limit_q   <= cfg_data;
				REG_WINDOW_LIMIT_MS:  window_limit_q  <= cfg_data;
				REG_LATENCY_LIMIT_MS: latency_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == LAST_IDX) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign busy = clearing_q;

	logic accept;
	assign accept = start && !busy;

	// stage 1 registers
	logic       valid_s1;
	ism_item_t  item_s1;
	logic       byp_s1;
	ism_entry_t byp_data_s1;

	// line table
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	ism_entry_t    ram_wdata;
	logic [EW-1:0] ram_rdata;

	logic [DATA_W-1:0] last_entry_q;

	// stage 1 datapath
	logic              ign;
	logic              wr_en;
	ism_entry_t        cur;
	ism_entry_t        upd;
	logic              over;
	logic [DATA_W-1:0] win_len;
	logic [DATA_W-1:0] base_cnt;
	logic [DATA_W-1:0] exit_len;
	ism_result_t       res;

	always_comb begin
		ign = !enable_q || item_s1.per_cpu_line || ({1'b0, item_s1.line_number} >= LINE_END);
		wr_en = valid_s1 && !ign && (item_s1.cmd == CMD_ENTRY);
		cur = byp_s1 ? byp_data_s1 : ism_entry_t'(ram_rdata);

		over = cur.event_count > count_limit_q;
		win_len = item_s1.now_ms - cur.window_start;
		base_cnt = over ? '0 : cur.event_count;
		upd.event_count = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + DATA_W'(1);
		upd.window_start = over ? item_s1.now_ms : cur.window_start;

		exit_len = item_s1.now_ms - last_entry_q;

		res = '0;
		if (ign) begin
			res.ignored = 1'b1;
		end else if (item_s1.cmd == CMD_ENTRY) begin
			res.storm_detected = over && (win_len < window_limit_q);
			res.elapsed_ms = over ? win_len : '0;
			res.line_count = upd.event_count;
		end else begin
			res.long_latency = exit_len >= latency_limit_q;
			res.elapsed_ms = exit_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_entry_q <= '0;
		end else if (wr_en) begin
			last_entry_q <= item_s1.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			// RAM read at this edge misses the write at this edge: forward it
			byp_s1   <= accept && wr_en &&
				(item.line_number[AW-1:0] == item_s1.line_number[AW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		byp_data_s1 <= upd;
	end

	always_comb begin
		ram_we    = clearing_q || wr_en;
		ram_waddr = clearing_q ? clr_idx_q : item_s1.line_number[AW-1:0];
		ram_wdata = clearing_q ? '0 : upd;
	end

	ism_ram #(
		.WIDTH(EW),
		.DEPTH(LINES)
	) u_line_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(item.line_number[AW-1:0]),
		.rdata(ram_rdata)
	);

	// result register
	logic        done_q;
	ism_result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`ISM_ASSERT_LATER2(a_accept_done, clk, arst_n, accept, done_q,
		"accepted beat did not give a result two cycles later")
	`ISM_ASSERT_NEVER(a_no_result_clearing, clk, arst_n, clearing_q && done_q,
		"result during table clearing")
	`ISM_ASSERT_IMPLY(a_ignored_zero, clk, arst_n, done_q && result_q.ignored,
		!result_q.storm_detected && !result_q.long_latency &&
		result_q.elapsed_ms == '0 && result_q.line_count == '0,
		"ignored result carries nonzero fields")
	`ISM_ASSERT_IMPLY(a_storm_restart, clk, arst_n, done_q && result_q.storm_detected,
		result_q.line_count == DATA_W'(1) && !result_q.long_latency,
		"storm result without window restart")
	`ISM_ASSERT_IMPLY(a_exit_fields, clk, arst_n, done_q && result_q.long_latency,
		result_q.line_count == '0 && !result_q.ignored,
		"latency result carries a line count")

endmodule

[tb/interrupt_storm_latency_monitor_tb.sv]
// Self-checking testbench for the interrupt storm and latency monitor.
`timescale 1ns / 1ps

module tb;
	import ism_pkg::*;

	localparam int LINES   = 256;
	localparam int MAX_GAP = 18;
	localparam int MAX_LOG = 50;

	// Mirrors the line table and limits; one expected result per accepted beat.
	class storm_scoreboard;
		logic              monitor_on;
		logic [DATA_W-1:0] count_limit;
		logic [DATA_W-1:0] window_limit;
		logic [DATA_W-1:0] latency_limit;
		logic [DATA_W-1:0] line_counts [LINES];
		logic [DATA_W-1:0] window_begin [LINES];
		logic [DATA_W-1:0] last_entry_ms;
		ism_result_t       expected_q [$];
		int                mismatches;

		function new();
			monitor_on    = 1'b0;
			count_limit   = COUNT_LIMIT_RST;
			window_limit  = WINDOW_LIMIT_RST;
			latency_limit = LATENCY_LIMIT_RST;
			last_entry_ms = '0;
			mismatches    = 0;
			foreach (line_counts[i]) begin
				line_counts[i]  = '0;
				window_begin[i] = '0;
			end
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
			case (idx)
				REG_MONITOR_ENABLE:   monitor_on    = val[0];
				REG_COUNT_LIMIT:      count_limit   = val;
				REG_WINDOW_LIMIT_MS:  window_limit  = val;
				REG_LATENCY_LIMIT_MS: latency_limit = val;
				default: ;
			endcase
		endfunction

		// predict the outcome of one accepted event and queue it
		function void note_event(input ism_item_t ev);
			ism_result_t       r;
			logic [DATA_W-1:0] cnt;
			int                idx;
			r   = '0;
			idx = int'(ev.line_number);
			if (!monitor_on || ev.per_cpu_line || ev.line_number >= LINES) begin
				r.ignored = 1'b1;
			end else if (ev.cmd == CMD_ENTRY) begin
				last_entry_ms = ev.now_ms;
				cnt = line_counts[idx];
				if (cnt > count_limit) begin
					r.elapsed_ms     = ev.now_ms - window_begin[idx];
					r.storm_detected = (r.elapsed_ms < window_limit);
					cnt               = '0;
					window_begin[idx] = ev.now_ms;
				end
				if (cnt != COUNT_MAX)
					cnt++;
				line_counts[idx] = cnt;
				r.line_count     = cnt;
			end else begin
				r.elapsed_ms   = ev.now_ms - last_entry_ms;
				r.long_latency = (r.elapsed_ms >= latency_limit);
			end
			expected_q.push_back(r);
		endfunction

		task report_mismatch(input string msg);
			if (mismatches < MAX_LOG)
				$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task compare_field(input string name, input logic [DATA_W-1:0] got,
				input logic [DATA_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_result(input ism_result_t got);
			ism_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
				return;
			end
			want = expected_q.pop_front();
			compare_field("ignored", DATA_W'(got.ignored), DATA_W'(want.ignored));
			compare_field("storm_detected", DATA_W'(got.storm_detected),
				DATA_W'(want.storm_detected));
			compare_field("long_latency", DATA_W'(got.long_latency),
				DATA_W'(want.long_latency));
			compare_field("elapsed_ms", got.elapsed_ms, want.elapsed_ms);
			compare_field("line_count", got.line_count, want.line_count);
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	ism_item_t            item = '0;
	logic                 done;
	ism_result_t          result;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	storm_scoreboard sb = new();

	logic [DATA_W-1:0] sim_ms = 32'hFFFF_FF00;
	bit                no_idle = 1'b0;
	int                stretch_left = 0;

	interrupt_storm_latency_monitor #(.LINES(LINES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// beats are taken and results checked at the same edge the DUT sees them
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_event(item);
		end
	end

	function automatic ism_item_t mk_event(input logic cmd, input logic [LINE_W-1:0] ln,
			input logic per_cpu, input logic [DATA_W-1:0] now);
		ism_item_t ev;
		ev.cmd          = cmd;
		ev.line_number  = ln;
		ev.per_cpu_line = per_cpu;
		ev.now_ms       = now;
		return ev;
	endfunction

	// start stays high across back-to-back beats
	task automatic send_event(input ism_item_t ev);
		int gap;
		if (stretch_left == 0) begin
			stretch_left = $urandom_range(5, 30);
			no_idle      = ($urandom_range(0, 3) == 0);
		end
		stretch_left--;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= ev;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [DATA_W-1:0] enable_word,
			input logic [DATA_W-1:0] cnt_lim, input logic [DATA_W-1:0] win_lim,
			input logic [DATA_W-1:0] lat_lim);
		logic [DATA_W-1:0] vals [4];
		vals = '{enable_word, cnt_lim, win_lim, lat_lim};
		for (int i = 0; i < 4; i++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.set_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_wen <= 1'b0;
	endtask

	task automatic advance_time();
		if ($urandom_range(0, 19) == 0)
			sim_ms = $urandom();
		else
			sim_ms += $urandom_range(0, 15);
	endtask

	// mostly entry/exit pairs on a few busy lines; noise beats are not counted
	task automatic random_traffic(input int n);
		int                sent;
		int                pick;
		logic [LINE_W-1:0] ln;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 9);
			ln   = ($urandom_range(0, 7) == 0) ? LINE_W'(255) : LINE_W'($urandom_range(0, 3));
			if (pick < 7) begin
				advance_time();
				send_event(mk_event(CMD_ENTRY, ln, 1'b0, sim_ms));
				advance_time();
				send_event(mk_event(CMD_EXIT, ln, 1'b0, sim_ms));
				sent += 2;
			end else if (pick == 7) begin
				send_event(mk_event(1'($urandom_range(0, 1)), LINE_W'($urandom_range(0, 1023)),
					1'($urandom_range(0, 1)), $urandom()));
			end else begin
				advance_time();
				send_event(mk_event(1'($urandom_range(0, 1)), ln, 1'b0, sim_ms));
				sent++;
			end
		end
	endtask

	task automatic run_phase(input logic [DATA_W-1:0] enable_word,
			input logic [DATA_W-1:0] cnt_lim, input logic [DATA_W-1:0] win_lim,
			input logic [DATA_W-1:0] lat_lim, input int n);
		drain();
		apply_settings(enable_word, cnt_lim, win_lim, lat_lim);
		random_traffic(n);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// monitor off out of reset
		send_event(mk_event(CMD_ENTRY, 10'd5, 1'b0, 32'd100));
		send_event(mk_event(CMD_EXIT, 10'd5, 1'b0, 32'd200));
		drain();

		// upper enable bits are dropped
		apply_settings(32'hFFFF_FFF3, COUNT_LIMIT_RST, WINDOW_LIMIT_RST, LATENCY_LIMIT_RST);
		send_event(mk_event(CMD_EXIT, 10'd0, 1'b0, 32'd5));
		send_event(mk_event(CMD_ENTRY, 10'd1, 1'b1, 32'd7));
		send_event(mk_event(CMD_ENTRY, 10'd256, 1'b0, 32'd8));
		send_event(mk_event(CMD_ENTRY, 10'd1023, 1'b0, 32'd9));
		send_event(mk_event(CMD_EXIT, 10'd1023, 1'b1, 32'd10));
		send_event(mk_event(CMD_ENTRY, 10'd255, 1'b0, 32'hFFFF_FFF0));
		send_event(mk_event(CMD_EXIT, 10'd255, 1'b0, 32'h0000_0010));
		send_event(mk_event(CMD_ENTRY, 10'd0, 1'b0, 32'd1000));
		send_event(mk_event(CMD_EXIT, 10'd0, 1'b0, 32'd1999));
		send_event(mk_event(CMD_EXIT, 10'd0, 1'b0, 32'd2000));
		drain();

		// storm on the third entry, quiet window on the fifth
		apply_settings(32'd1, 32'd1, 32'd100, 32'd0);
		send_event(mk_event(CMD_ENTRY, 10'd7, 1'b0, 32'd10));
		send_event(mk_event(CMD_ENTRY, 10'd7, 1'b0, 32'd20));
		send_event(mk_event(CMD_ENTRY, 10'd7, 1'b0, 32'd30));
		send_event(mk_event(CMD_ENTRY, 10'd7, 1'b0, 32'd40));
		send_event(mk_event(CMD_ENTRY, 10'd7, 1'b0, 32'd200));
		send_event(mk_event(CMD_EXIT, 10'd7, 1'b0, 32'd200));
		drain();

		// time running backwards wraps to the largest difference
		apply_settings(32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(mk_event(CMD_ENTRY, 10'd3, 1'b0, 32'd50));
		send_event(mk_event(CMD_ENTRY, 10'd3, 1'b0, 32'd60));
		send_event(mk_event(CMD_ENTRY, 10'd3, 1'b0, 32'd59));
		send_event(mk_event(CMD_EXIT, 10'd3, 1'b0, 32'd58));
		drain();

		apply_settings(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_event(mk_event(CMD_ENTRY, 10'd2, 1'b0, 32'd70));

		run_phase(32'd1, 32'd2, 32'd100, 32'd20, 80);
		run_phase(32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);
		run_phase(32'd1, 32'd4, 32'd200, 32'd0, 80);
		run_phase(32'd0, 32'd1, 32'd50, 32'd10, 20);
		run_phase(32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1, 60);
		run_phase(32'd1, 32'd1, 32'd40, 32'd8, 90);
		run_phase(32'd1, 32'd3, 32'd1000, 32'd30, 80);
		drain();

		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
